FILE: rtl/programmable_interrupt_controller_defines.svh
`ifndef PROGRAMMABLE_INTERRUPT_CONTROLLER_DEFINES_SVH
`define PROGRAMMABLE_INTERRUPT_CONTROLLER_DEFINES_SVH

// check a consequence in the same cycle
`define PIC_ASSERT_NOW(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("pic assertion failed");

// check a consequence in the following cycle
`define PIC_ASSERT_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("pic assertion failed");

`endif

FILE: rtl/pic_pkg.sv
package pic_pkg;

   localparam int NUM_LINES = 8;
   localparam int LVL_W     = $clog2(NUM_LINES) + 1;
   localparam int BASE_W    = 5;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_UPDATE = 2'd2;
   localparam logic [1:0] FUNC_ACK    = 2'd3;

   localparam logic [1:0] INIT_READY = 2'd0;
   localparam logic [1:0] INIT_ICW2  = 2'd1;
   localparam logic [1:0] INIT_ICW3  = 2'd2;
   localparam logic [1:0] INIT_ICW4  = 2'd3;

   localparam int BIT_ICW1 = 4;
   localparam int BIT_OCW3 = 3;
   localparam int BIT_EOI  = 5;
   localparam int BIT_SL   = 6;
   localparam int BIT_RR   = 1;
   localparam int BIT_RIS  = 0;
   localparam int BIT_IC4  = 0;
   localparam int BIT_SNGL = 1;
   localparam int BIT_LTIM = 3;
   localparam int BIT_AEOI = 1;

   localparam logic [NUM_LINES-1:0] MASK_RESET = '1;

   typedef struct packed {
      logic [1:0]           func;
      logic                 port_sel;
      logic [7:0]           wdata;
      logic [NUM_LINES-1:0] irq_lines;
   } req_item_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       int_pending;
      logic [7:0] vector;
      logic       in_init;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_stage_type;

   // lowest set bit, NUM_LINES when none
   function automatic logic [LVL_W-1:0] top_level(input logic [NUM_LINES-1:0] bits);
      logic [LVL_W-1:0] lvl;
      lvl = LVL_W'(NUM_LINES);
      for (int i = NUM_LINES - 1; i >= 0; i--) begin
         if (bits[i]) lvl = LVL_W'(i);
      end
      return lvl;
   endfunction

endpackage

FILE: rtl/pic_if.sv
interface pic_req_if;
   import pic_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic                 port_sel;
   logic [7:0]           wdata;
   logic [NUM_LINES-1:0] irq_lines;

   modport source (output valid, func, port_sel, wdata, irq_lines, input ready);
   modport sink   (input valid, func, port_sel, wdata, irq_lines, output ready);
endinterface

interface pic_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] rdata;
   logic       int_pending;
   logic [7:0] vector;
   logic       in_init;

   modport source (output valid, rdata, int_pending, vector, in_init, input ready);
   modport sink   (input valid, rdata, int_pending, vector, in_init, output ready);
endinterface

FILE: rtl/pic_in_stage.sv
module pic_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pic_pkg::req_item_type in_item,
   output logic                  in_ready,
   input  logic                  advance,
   output pic_pkg::req_stage_type stage
);
   import pic_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

FILE: rtl/pic_core.sv
module pic_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  pic_pkg::req_item_type item,
   output pic_pkg::rsp_item_type result
);
   import pic_pkg::*;

   `include "programmable_interrupt_controller_defines.svh"

   logic [1:0]           init_step_ff,   init_step_in;
   logic [BASE_W-1:0]    vector_base_ff, vector_base_in;
   logic                 need_icw4_ff,   need_icw4_in;
   logic                 single_mode_ff, single_mode_in;
   logic                 level_mode_ff,  level_mode_in;
   logic                 auto_eoi_ff,    auto_eoi_in;
   logic [7:0]           cascade_ff,     cascade_in;
   logic [NUM_LINES-1:0] mask_ff,        mask_in;
   logic [NUM_LINES-1:0] request_ff,     request_in;
   logic [NUM_LINES-1:0] service_ff,     service_in;
   logic                 read_isr_ff,    read_isr_in;
   logic [NUM_LINES-1:0] prev_lines_ff,  prev_lines_in;

   logic [LVL_W-1:0] ack_lvl;
   logic [LVL_W-1:0] isr_top;
   logic [LVL_W-1:0] eoi_lvl;
   logic [LVL_W-1:0] new_req_top;
   logic [LVL_W-1:0] new_isr_top;
   logic [7:0]       d;

   assign d       = item.wdata;
   assign isr_top = top_level(service_ff);
   assign ack_lvl = (top_level(request_ff & ~mask_ff) < isr_top) ?
                    top_level(request_ff & ~mask_ff) : LVL_W'(NUM_LINES);

   always_comb begin
      init_step_in   = init_step_ff;
      vector_base_in = vector_base_ff;
      need_icw4_in   = need_icw4_ff;
      single_mode_in = single_mode_ff;
      level_mode_in  = level_mode_ff;
      auto_eoi_in    = auto_eoi_ff;
      cascade_in     = cascade_ff;
      mask_in        = mask_ff;
      request_in     = request_ff;
      service_in     = service_ff;
      read_isr_in    = read_isr_ff;
      prev_lines_in  = prev_lines_ff;
      eoi_lvl        = d[BIT_SL] ? {1'b0, d[2:0]} : isr_top;
      result.rdata   = '0;
      result.vector  = '0;

      case (item.func)
         FUNC_WRITE: begin
            if (!item.port_sel) begin
               if (d[BIT_ICW1]) begin
                  need_icw4_in   = d[BIT_IC4];
                  single_mode_in = d[BIT_SNGL];
                  level_mode_in  = d[BIT_LTIM];
                  if (!d[BIT_IC4]) auto_eoi_in = 1'b0;
                  mask_in      = '0;
                  request_in   = '0;
                  service_in   = '0;
                  read_isr_in  = 1'b0;
                  init_step_in = INIT_ICW2;
               end else if (d[BIT_OCW3]) begin
                  if (d[BIT_RR]) read_isr_in = d[BIT_RIS];
               end else if (d[BIT_EOI]) begin
                  if (eoi_lvl < LVL_W'(NUM_LINES)) begin
                     service_in[eoi_lvl[LVL_W-2:0]] = 1'b0;
                  end
               end
            end else begin
               unique case (init_step_ff)
                  INIT_ICW2: begin
                     vector_base_in = d[7:3];
                     init_step_in   = single_mode_ff ?
                                      (need_icw4_ff ? INIT_ICW4 : INIT_READY) : INIT_ICW3;
                  end
                  INIT_ICW3: begin
                     cascade_in   = d;
                     init_step_in = need_icw4_ff ? INIT_ICW4 : INIT_READY;
                  end
                  INIT_ICW4: begin
                     auto_eoi_in  = d[BIT_AEOI];
                     init_step_in = INIT_READY;
                  end
                  default: begin
                     mask_in = d;
                  end
               endcase
            end
         end
         FUNC_READ: begin
            if (item.port_sel) begin
               result.rdata = mask_ff;
            end else begin
               result.rdata = read_isr_ff ? service_ff : request_ff;
            end
         end
         FUNC_UPDATE: begin
            if (level_mode_ff) begin
               request_in = item.irq_lines;
            end else begin
               request_in = request_ff | (item.irq_lines & ~prev_lines_ff);
            end
            prev_lines_in = item.irq_lines;
         end
         default: begin
            if (ack_lvl < LVL_W'(NUM_LINES)) begin
               request_in[ack_lvl[LVL_W-2:0]] = 1'b0;
               if (!auto_eoi_ff) service_in[ack_lvl[LVL_W-2:0]] = 1'b1;
               result.vector = {vector_base_ff, ack_lvl[LVL_W-2:0]};
            end else begin
               result.vector = {vector_base_ff, 3'd7};
            end
         end
      endcase

      new_req_top        = top_level(request_in & ~mask_in);
      new_isr_top        = top_level(service_in);
      result.int_pending = new_req_top < new_isr_top;
      result.in_init     = init_step_in != INIT_READY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_step_ff   <= INIT_READY;
         vector_base_ff <= '0;
         need_icw4_ff   <= 1'b0;
         single_mode_ff <= 1'b0;
         level_mode_ff  <= 1'b0;
         auto_eoi_ff    <= 1'b0;
         cascade_ff     <= '0;
         mask_ff        <= MASK_RESET;
         request_ff     <= '0;
         service_ff     <= '0;
         read_isr_ff    <= 1'b0;
         prev_lines_ff  <= '0;
      end else if (advance) begin
         init_step_ff   <= init_step_in;
         vector_base_ff <= vector_base_in;
         need_icw4_ff   <= need_icw4_in;
         single_mode_ff <= single_mode_in;
         level_mode_ff  <= level_mode_in;
         auto_eoi_ff    <= auto_eoi_in;
         cascade_ff     <= cascade_in;
         mask_ff        <= mask_in;
         request_ff     <= request_in;
         service_ff     <= service_in;
         read_isr_ff    <= read_isr_in;
         prev_lines_ff  <= prev_lines_in;
      end
   end

   `PIC_ASSERT_NEXT(a_icw1_restarts,
      advance && item.func == FUNC_WRITE && !item.port_sel && item.wdata[BIT_ICW1],
      init_step_ff == INIT_ICW2 && mask_ff == '0 && service_ff == '0)
   `PIC_ASSERT_NEXT(a_isr_set_by_ack_only,
      advance && item.func != FUNC_ACK,
      (service_ff & ~$past(service_ff)) == '0)
   `PIC_ASSERT_NEXT(a_aeoi_keeps_isr,
      advance && item.func == FUNC_ACK && auto_eoi_ff,
      service_ff == $past(service_ff))

endmodule

FILE: rtl/pic_out_stage.sv
module pic_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  pic_pkg::rsp_item_type result,
   output logic                  can_load,
   output logic                  out_valid,
   output pic_pkg::rsp_item_type out_item,
   input  logic                  out_ready
);
   import pic_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/programmable_interrupt_controller.sv
// Channel  Dir  Fields
// req_if   in   func, port_sel, wdata, irq_lines
// rsp_if   out  rdata, int_pending, vector, in_init
//
// One item per cycle sustained while rsp_if is ready.
// Each item passes an input register, then one decode and priority-encode
// step that updates the controller state and loads the result register.
// Synchronous reset returns every controller register to its reset value.
// A stalled result holds; the input register still takes one more item.
module programmable_interrupt_controller (
   input  logic      clock,
   input  logic      reset,
   pic_req_if.sink   req_if,
   pic_rsp_if.source rsp_if
);
   import pic_pkg::*;

   req_item_type  req_item;
   req_stage_type stage;
   rsp_item_type  result;
   rsp_item_type  rsp_item;
   logic          can_load;
   logic          advance;

   assign req_item.func      = req_if.func;
   assign req_item.port_sel  = req_if.port_sel;
   assign req_item.wdata     = req_if.wdata;
   assign req_item.irq_lines = req_if.irq_lines;

   assign advance = stage.valid && can_load;

   pic_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_item  (req_item),
      .in_ready (req_if.ready),
      .advance  (advance),
      .stage    (stage)
   );

   pic_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage.item),
      .result  (result)
   );

   pic_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_load  (can_load),
      .out_valid (rsp_if.valid),
      .out_item  (rsp_item),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.rdata       = rsp_item.rdata;
   assign rsp_if.int_pending = rsp_item.int_pending;
   assign rsp_if.vector      = rsp_item.vector;
   assign rsp_if.in_init     = rsp_item.in_init;

endmodule

FILE: tb/programmable_interrupt_controller_tb.sv
`timescale 1ns / 1ps

module programmable_interrupt_controller_tb;
   import pic_pkg::*;

   localparam int RANDOM_ITEMS = 1650;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 200;
   localparam int MAX_PRINTED  = 100;

   localparam logic CMD_PORT  = 1'b0;
   localparam logic DATA_PORT = 1'b1;

   localparam logic [7:0] ICW1_FLAG = 8'(1 << BIT_ICW1);
   localparam logic [7:0] OCW3_FLAG = 8'(1 << BIT_OCW3);
   localparam logic [7:0] EOI_FLAG  = 8'(1 << BIT_EOI);
   localparam logic [7:0] SL_FLAG   = 8'(1 << BIT_SL);
   localparam logic [7:0] RR_FLAG   = 8'(1 << BIT_RR);
   localparam logic [7:0] RIS_FLAG  = 8'(1 << BIT_RIS);
   localparam logic [7:0] IC4_FLAG  = 8'(1 << BIT_IC4);
   localparam logic [7:0] SNGL_FLAG = 8'(1 << BIT_SNGL);
   localparam logic [7:0] LTIM_FLAG = 8'(1 << BIT_LTIM);
   localparam logic [7:0] AEOI_FLAG = 8'(1 << BIT_AEOI);

   logic clock = 1'b0;
   logic reset = 1'b1;

   pic_req_if req_bus ();
   pic_rsp_if rsp_bus ();

   programmable_interrupt_controller dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #4 clock = ~clock;

   // controller state as the checker sees it
   logic [1:0]           ctl_step    = INIT_READY;
   logic [BASE_W-1:0]    ctl_base    = '0;
   logic                 ctl_icw4    = 1'b0;
   logic                 ctl_single  = 1'b0;
   logic                 ctl_level   = 1'b0;
   logic                 ctl_aeoi    = 1'b0;
   logic [7:0]           ctl_cascade = '0;
   logic [NUM_LINES-1:0] ctl_mask    = MASK_RESET;
   logic [NUM_LINES-1:0] ctl_irr     = '0;
   logic [NUM_LINES-1:0] ctl_isr     = '0;
   logic                 ctl_ris     = 1'b0;
   logic [NUM_LINES-1:0] ctl_prev    = '0;

   req_item_type stimulus_items[$];
   rsp_item_type awaited_responses[$];
   req_item_type offered;

   int total_items    = 0;
   int items_accepted = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int init_count     = 0;
   int served_acks    = 0;
   int spurious_acks  = 0;
   int read_count     = 0;
   int send_gap       = 0;
   int send_burst     = 0;
   int recv_stall     = 0;
   int recv_burst     = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int quiet_cycles   = 0;

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("%0t: mismatch: %s", $realtime, what);
   endtask

   function automatic int lowest_set(input logic [NUM_LINES-1:0] bits);
      for (int i = 0; i < NUM_LINES; i++)
         if (bits[i]) return i;
      return NUM_LINES;
   endfunction

   function automatic int next_served_level();
      int req_top;
      int svc_top;
      req_top = lowest_set(ctl_irr & ~ctl_mask);
      svc_top = lowest_set(ctl_isr);
      return (req_top < svc_top) ? req_top : NUM_LINES;
   endfunction

   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst = $urandom_range(30, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic apply_event(input req_item_type it, output rsp_item_type r);
      int lvl;
      r = '0;
      case (it.func)
         FUNC_WRITE: begin
            if (it.port_sel == CMD_PORT) begin
               if (it.wdata[BIT_ICW1]) begin
                  init_count++;
                  ctl_icw4   = it.wdata[BIT_IC4];
                  ctl_single = it.wdata[BIT_SNGL];
                  ctl_level  = it.wdata[BIT_LTIM];
                  if (!ctl_icw4) ctl_aeoi = 1'b0;
                  ctl_mask = '0;
                  ctl_irr  = '0;
                  ctl_isr  = '0;
                  ctl_ris  = 1'b0;
                  ctl_step = INIT_ICW2;
               end else if (it.wdata[BIT_OCW3]) begin
                  if (it.wdata[BIT_RR]) ctl_ris = it.wdata[BIT_RIS];
               end else if (it.wdata[BIT_EOI]) begin
                  lvl = it.wdata[BIT_SL] ? int'(it.wdata[2:0]) : lowest_set(ctl_isr);
                  if (lvl < NUM_LINES) ctl_isr[lvl] = 1'b0;
               end
            end else begin
               case (ctl_step)
                  INIT_ICW2: begin
                     ctl_base = it.wdata[7:3];
                     ctl_step = ctl_single ? (ctl_icw4 ? INIT_ICW4 : INIT_READY) : INIT_ICW3;
                  end
                  INIT_ICW3: begin
                     ctl_cascade = it.wdata;
                     ctl_step = ctl_icw4 ? INIT_ICW4 : INIT_READY;
                  end
                  INIT_ICW4: begin
                     ctl_aeoi = it.wdata[BIT_AEOI];
                     ctl_step = INIT_READY;
                  end
                  default: ctl_mask = it.wdata;
               endcase
            end
         end
         FUNC_READ: begin
            read_count++;
            if (it.port_sel == DATA_PORT) r.rdata = ctl_mask;
            else r.rdata = ctl_ris ? ctl_isr : ctl_irr;
         end
         FUNC_UPDATE: begin
            if (ctl_level) ctl_irr = it.irq_lines;
            else ctl_irr = ctl_irr | (it.irq_lines & ~ctl_prev);
            ctl_prev = it.irq_lines;
         end
         default: begin
            lvl = next_served_level();
            if (lvl < NUM_LINES) begin
               served_acks++;
               ctl_irr[lvl] = 1'b0;
               if (!ctl_aeoi) ctl_isr[lvl] = 1'b1;
               r.vector = {ctl_base, 3'(lvl)};
            end else begin
               spurious_acks++;
               r.vector = {ctl_base, 3'd7};
            end
         end
      endcase
      r.int_pending = next_served_level() < NUM_LINES;
      r.in_init     = ctl_step != INIT_READY;
   endtask

   task automatic queue_item(input logic [1:0] f, input logic p, input logic [7:0] d,
                             input logic [7:0] l);
      req_item_type it;
      it.func      = f;
      it.port_sel  = p;
      it.wdata     = d;
      it.irq_lines = l;
      stimulus_items.push_back(it);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.func      <= FUNC_READ;
         req_bus.port_sel  <= CMD_PORT;
         req_bus.wdata     <= '0;
         req_bus.irq_lines <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            rsp_item_type predicted;
            apply_event(offered, predicted);
            awaited_responses.push_back(predicted);
            items_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (stimulus_items.size() > 0) begin
               offered = stimulus_items.pop_front();
               req_bus.func      <= offered.func;
               req_bus.port_sel  <= offered.port_sel;
               req_bus.wdata     <= offered.wdata;
               req_bus.irq_lines <= offered.irq_lines;
               req_bus.valid     <= 1'b1;
               send_gap = pick_gap(send_burst);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_item_type want;
            results_seen++;
            if (awaited_responses.size() == 0) begin
               flag_mismatch("result with no item outstanding");
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_bus.rdata !== want.rdata)
                  flag_mismatch($sformatf("rdata %h, want %h", rsp_bus.rdata, want.rdata));
               if (rsp_bus.int_pending !== want.int_pending)
                  flag_mismatch($sformatf("int_pending %b, want %b",
                                          rsp_bus.int_pending, want.int_pending));
               if (rsp_bus.vector !== want.vector)
                  flag_mismatch($sformatf("vector %h, want %h", rsp_bus.vector, want.vector));
               if (rsp_bus.in_init !== want.in_init)
                  flag_mismatch($sformatf("in_init %b, want %b", rsp_bus.in_init, want.in_init));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && results_seen >= 500) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            recv_stall = pick_gap(recv_burst);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int directed;
      int ops;
      int r;
      logic [7:0] icw;
      logic [7:0] cmd;

      // reset state, spurious acknowledge, masked update
      queue_item(FUNC_READ, DATA_PORT, 8'($urandom), 8'($urandom));
      queue_item(FUNC_READ, CMD_PORT, 8'($urandom), 8'($urandom));
      queue_item(FUNC_ACK, CMD_PORT, 8'($urandom), 8'($urandom));
      queue_item(FUNC_UPDATE, DATA_PORT, 8'($urandom), 8'hFF);
      // cascade init with ICW4 and auto EOI, command and acknowledge mid-sequence
      queue_item(FUNC_WRITE, CMD_PORT, ICW1_FLAG | IC4_FLAG, 8'($urandom));
      queue_item(FUNC_WRITE, CMD_PORT, OCW3_FLAG | RR_FLAG | RIS_FLAG, 8'($urandom));
      queue_item(FUNC_ACK, DATA_PORT, 8'($urandom), 8'($urandom));
      queue_item(FUNC_WRITE, DATA_PORT, 8'hF8, 8'($urandom));
      queue_item(FUNC_WRITE, DATA_PORT, 8'h04, 8'($urandom));
      queue_item(FUNC_WRITE, DATA_PORT, AEOI_FLAG, 8'($urandom));
      queue_item(FUNC_UPDATE, DATA_PORT, 8'($urandom), 8'h00);
      queue_item(FUNC_UPDATE, CMD_PORT, 8'($urandom), 8'hFF);
      queue_item(FUNC_ACK, CMD_PORT, 8'($urandom), 8'($urandom));
      // single, level triggered, ICW4 without auto EOI
      queue_item(FUNC_WRITE, CMD_PORT, ICW1_FLAG | IC4_FLAG | SNGL_FLAG | LTIM_FLAG,
                 8'($urandom));
      queue_item(FUNC_WRITE, DATA_PORT, 8'h00, 8'($urandom));
      queue_item(FUNC_WRITE, DATA_PORT, ~AEOI_FLAG, 8'($urandom));
      queue_item(FUNC_UPDATE, DATA_PORT, 8'($urandom), 8'h81);
      queue_item(FUNC_ACK, CMD_PORT, 8'($urandom), 8'($urandom));
      queue_item(FUNC_READ, CMD_PORT, 8'($urandom), 8'($urandom));
      // specific EOI, non-specific EOI with rotate, no-op OCW2, OCW3 without RR
      queue_item(FUNC_WRITE, CMD_PORT, EOI_FLAG | SL_FLAG | 8'h07, 8'($urandom));
      queue_item(FUNC_WRITE, CMD_PORT, 8'h80 | EOI_FLAG, 8'($urandom));
      queue_item(FUNC_WRITE, CMD_PORT, 8'h80, 8'($urandom));
      queue_item(FUNC_WRITE, CMD_PORT, OCW3_FLAG | RIS_FLAG, 8'($urandom));
      // no ICW4: auto EOI drops, ICW3 stored
      queue_item(FUNC_WRITE, CMD_PORT, ICW1_FLAG, 8'($urandom));
      queue_item(FUNC_WRITE, DATA_PORT, 8'h55, 8'($urandom));
      queue_item(FUNC_WRITE, DATA_PORT, 8'hAA, 8'($urandom));
      queue_item(FUNC_READ, DATA_PORT, 8'($urandom), 8'($urandom));
      directed = stimulus_items.size();

      while (stimulus_items.size() < directed + RANDOM_ITEMS) begin
         icw = 8'($urandom);
         icw[BIT_ICW1] = 1'b1;
         queue_item(FUNC_WRITE, CMD_PORT, icw, 8'($urandom));
         if ($urandom_range(0, 9) != 0) begin
            queue_item(FUNC_WRITE, DATA_PORT, 8'($urandom), 8'($urandom));
            if (!icw[BIT_SNGL])
               queue_item(FUNC_WRITE, DATA_PORT, 8'($urandom), 8'($urandom));
            if (icw[BIT_IC4])
               queue_item(FUNC_WRITE, DATA_PORT, 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 9) < 6)
               queue_item(FUNC_WRITE, DATA_PORT, 8'h00, 8'($urandom));
         end
         ops = $urandom_range(15, 60);
         repeat (ops) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               queue_item(FUNC_UPDATE, 1'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 52) begin
               queue_item(FUNC_ACK, 1'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 64) begin
               queue_item(FUNC_READ, 1'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 70) begin
               queue_item(FUNC_WRITE, DATA_PORT, 8'($urandom), 8'($urandom));
            end else if (r < 82) begin
               cmd = 8'($urandom);
               cmd[BIT_ICW1] = 1'b0;
               cmd[BIT_OCW3] = 1'b0;
               if ($urandom_range(0, 9) != 0) cmd[BIT_EOI] = 1'b1;
               queue_item(FUNC_WRITE, CMD_PORT, cmd, 8'($urandom));
            end else if (r < 90) begin
               cmd = 8'($urandom);
               cmd[BIT_ICW1] = 1'b0;
               cmd[BIT_OCW3] = 1'b1;
               queue_item(FUNC_WRITE, CMD_PORT, cmd, 8'($urandom));
            end else begin
               queue_item(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
            end
         end
      end
      total_items = stimulus_items.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < total_items) @(posedge clock);
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d items, %0d results: %0d init sequences, %0d reads,", total_items,
               results_seen, init_count, read_count);
      $display("%0d served and %0d spurious acknowledges", served_acks, spurious_acks);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pic_pkg.sv
rtl/pic_if.sv
rtl/pic_in_stage.sv
rtl/pic_core.sv
rtl/pic_out_stage.sv
rtl/programmable_interrupt_controller.sv
tb/programmable_interrupt_controller_tb.sv
